/* rtl/script_token_scanner_defines.svh */
// assertion macros for the script token scanner checker
`ifndef SCRIPT_TOKEN_SCANNER_DEFINES_SVH
`define SCRIPT_TOKEN_SCANNER_DEFINES_SVH

// check that is ignored while reset is held
`define STSC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("stsc check failed");

// check that also holds across reset
`define STSC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("stsc reset check failed");

`endif

/* rtl/stsc_pkg.sv */
// types, constants and helper functions for the script token scanner
package stsc_pkg;

    localparam int POSITION_BITS_DEF = 20;
    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int FIELD_BITS        = 20;
    localparam int KIND_BITS         = 6;
    localparam int OUT_DEPTH         = 4;
    localparam int KW_COUNT          = 15;
    localparam int KW_MAX_LEN        = 8;

    localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

    localparam logic [KIND_BITS-1:0] KIND_LPAREN        = 6'd0;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN        = 6'd1;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE        = 6'd2;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE        = 6'd3;
    localparam logic [KIND_BITS-1:0] KIND_COMMA         = 6'd4;
    localparam logic [KIND_BITS-1:0] KIND_DOT           = 6'd5;
    localparam logic [KIND_BITS-1:0] KIND_MINUS         = 6'd6;
    localparam logic [KIND_BITS-1:0] KIND_PLUS          = 6'd7;
    localparam logic [KIND_BITS-1:0] KIND_SEMICOLON     = 6'd8;
    localparam logic [KIND_BITS-1:0] KIND_SLASH         = 6'd9;
    localparam logic [KIND_BITS-1:0] KIND_STAR          = 6'd10;
    localparam logic [KIND_BITS-1:0] KIND_BANG          = 6'd11;
    localparam logic [KIND_BITS-1:0] KIND_BANG_EQUAL    = 6'd12;
    localparam logic [KIND_BITS-1:0] KIND_EQUAL         = 6'd13;
    localparam logic [KIND_BITS-1:0] KIND_EQUAL_EQUAL   = 6'd14;
    localparam logic [KIND_BITS-1:0] KIND_GREATER       = 6'd15;
    localparam logic [KIND_BITS-1:0] KIND_GREATER_EQUAL = 6'd16;
    localparam logic [KIND_BITS-1:0] KIND_LESS          = 6'd17;
    localparam logic [KIND_BITS-1:0] KIND_LESS_EQUAL    = 6'd18;
    localparam logic [KIND_BITS-1:0] KIND_IDENT         = 6'd19;
    localparam logic [KIND_BITS-1:0] KIND_STRING        = 6'd20;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER        = 6'd21;
    localparam logic [KIND_BITS-1:0] KIND_AND           = 6'd22;
    localparam logic [KIND_BITS-1:0] KIND_CLASS         = 6'd23;
    localparam logic [KIND_BITS-1:0] KIND_ELSE          = 6'd24;
    localparam logic [KIND_BITS-1:0] KIND_FALSE         = 6'd25;
    localparam logic [KIND_BITS-1:0] KIND_FUNCTION      = 6'd26;
    localparam logic [KIND_BITS-1:0] KIND_IF            = 6'd27;
    localparam logic [KIND_BITS-1:0] KIND_NIL           = 6'd28;
    localparam logic [KIND_BITS-1:0] KIND_OR            = 6'd29;
    localparam logic [KIND_BITS-1:0] KIND_PRINT         = 6'd30;
    localparam logic [KIND_BITS-1:0] KIND_RETURN        = 6'd31;
    localparam logic [KIND_BITS-1:0] KIND_SUPER         = 6'd32;
    localparam logic [KIND_BITS-1:0] KIND_TRUE          = 6'd33;
    localparam logic [KIND_BITS-1:0] KIND_VAR           = 6'd34;
    localparam logic [KIND_BITS-1:0] KIND_WHILE         = 6'd35;
    localparam logic [KIND_BITS-1:0] KIND_ERR_STRING    = 6'd36;
    localparam logic [KIND_BITS-1:0] KIND_ERR_CHAR      = 6'd37;
    localparam logic [KIND_BITS-1:0] KIND_END           = 6'd38;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = "\t";
    localparam logic [7:0] CH_NL     = "\n";
    localparam logic [7:0] CH_CR     = "\r";
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_QUOTE  = "\"";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_EQUAL  = "=";
    localparam logic [7:0] CH_LESS   = "<";
    localparam logic [7:0] CH_GREATER = ">";
    localparam logic [7:0] CH_UNDER  = "_";

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_INT,
        MODE_FRAC,
        MODE_STRING,
        MODE_OP
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_source;
    } in_item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]  token_kind;
        logic [FIELD_BITS-1:0] token_offset;
        logic [FIELD_BITS-1:0] token_length;
        logic [FIELD_BITS-1:0] line_number;
        logic                  last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [8*KW_MAX_LEN-1:0] text;
        logic [3:0]              len;
        logic [KIND_BITS-1:0]    kind;
    } kw_entry_t;

    localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
        '{"while",    4'd5, KIND_WHILE},
        '{"if",       4'd2, KIND_IF},
        '{"else",     4'd4, KIND_ELSE},
        '{"True",     4'd4, KIND_TRUE},
        '{"False",    4'd5, KIND_FALSE},
        '{"Nil",      4'd3, KIND_NIL},
        '{"or",       4'd2, KIND_OR},
        '{"and",      4'd3, KIND_AND},
        '{"return",   4'd6, KIND_RETURN},
        '{"var",      4'd3, KIND_VAR},
        '{"super",    4'd5, KIND_SUPER},
        '{"print",    4'd5, KIND_PRINT},
        '{"class",    4'd5, KIND_CLASS},
        '{"function", 4'd8, KIND_FUNCTION},
        '{"for",      4'd3, KIND_FUNCTION}
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == CH_UNDER);
    endfunction

    function automatic logic is_op_char(input logic [7:0] c);
        return (c == CH_BANG) || (c == CH_EQUAL) || (c == CH_LESS) || (c == CH_GREATER);
    endfunction

    function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ",":     k = KIND_COMMA;
            ".":     k = KIND_DOT;
            "-":     k = KIND_MINUS;
            "+":     k = KIND_PLUS;
            ";":     k = KIND_SEMICOLON;
            "*":     k = KIND_STAR;
            default: k = KIND_ERR_CHAR;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_BITS-1:0] op_kind(input logic [7:0] c, input logic with_eq);
        logic [KIND_BITS-1:0] k;
        case (c)
            CH_BANG:  k = with_eq ? KIND_BANG_EQUAL : KIND_BANG;
            CH_EQUAL: k = with_eq ? KIND_EQUAL_EQUAL : KIND_EQUAL;
            CH_LESS:  k = with_eq ? KIND_LESS_EQUAL : KIND_LESS;
            default:  k = with_eq ? KIND_GREATER_EQUAL : KIND_GREATER;
        endcase
        return k;
    endfunction

    // len is zero when the word is longer than any keyword
    function automatic logic [KIND_BITS-1:0] kw_lookup(
        input logic [KW_MAX_LEN-1:0][7:0] w,
        input logic [3:0]                 len
    );
        logic [KIND_BITS-1:0] k;
        logic                 hit;
        k = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            hit = (len == KW_TABLE[i].len);
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                if (j < int'(KW_TABLE[i].len)) begin
                    if (w[j] != KW_TABLE[i].text[8*(int'(KW_TABLE[i].len)-1-j) +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                k = KW_TABLE[i].kind;
            end
        end
        return k;
    endfunction

endpackage

/* rtl/script_token_scanner.sv */
// streaming lexer: source bytes in, tokens out through a small result queue
//
//  channel | direction | ports                     | payload
//  --------+-----------+---------------------------+------------------------
//  source  | in        | s_valid s_ready s_data    | in_item_t  (one byte)
//  tokens  | out       | m_valid m_ready m_data    | out_item_t (one token)
//
// one source item is taken per cycle while s_ready is high; its zero, one or two tokens
// are written into a four entry result queue in the same edge and reach m_ in order, behind any queued ones.
// s_ready is low while the queue holds more than two tokens.
// aresetn is synchronous: mode idle, offsets zero, line one, queue empty.
// after the end-of-source item all further items are taken and dropped.
module script_token_scanner
    import stsc_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int PB          = POSITION_BITS;
    localparam int KW_IDX_BITS = $clog2(KEYWORD_CHARS);
    localparam int WIDE_BITS   = (PB > FIELD_BITS) ? PB : FIELD_BITS;
    localparam int QPTR        = $clog2(OUT_DEPTH);

    scan_mode_t              mode_reg, mode_next;
    logic [7:0]              pend_reg, pend_next;
    logic [PB-1:0]           ts_reg, ts_next;
    logic [PB-1:0]           bp_reg, bp_next;
    logic [FIELD_BITS-1:0]   line_reg, line_next;
    logic                    fin_reg, fin_next;
    logic [7:0]              word_reg [KEYWORD_CHARS];
    logic                    word_we;
    logic [KW_IDX_BITS-1:0]  word_idx;

    out_item_t               q_reg [OUT_DEPTH];
    logic [QPTR-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [QPTR:0]           cnt_reg;
    logic [1:0]              n_res, n_wr;
    out_item_t               r0, r1;

    logic                    s_acc, m_acc;
    logic [7:0]              c;
    logic                    eos;
    logic                    is_blank, is_nl, dig, alp, opc, quote, slash;
    logic [PB-1:0]           bp_inc, len_cur, len_after, len_start;
    logic [FIELD_BITS-1:0]   line_inc;
    logic                    take_start, flush_able;
    logic [KIND_BITS-1:0]    flush_kind;
    logic [3:0]              kw_len;
    logic [KW_MAX_LEN-1:0][7:0] kw_word;
    logic                    flush_v, sec_v;
    out_item_t               flush_tok, sec_tok;

    function automatic logic [FIELD_BITS-1:0] sat_field(input logic [PB-1:0] v);
        logic [WIDE_BITS-1:0] wide;
        wide = WIDE_BITS'(v);
        return (wide > WIDE_BITS'(FIELD_MAX)) ? FIELD_MAX : wide[FIELD_BITS-1:0];
    endfunction

    function automatic out_item_t mk_tok(
        input logic [KIND_BITS-1:0]  kind,
        input logic [PB-1:0]         off,
        input logic [PB-1:0]         len,
        input logic [FIELD_BITS-1:0] line
    );
        out_item_t t;
        t.token_kind   = kind;
        t.token_offset = sat_field(off);
        t.token_length = sat_field(len);
        t.line_number  = line;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    assign s_ready = (cnt_reg <= (QPTR+1)'(OUT_DEPTH - 2));
    assign s_acc   = s_valid && s_ready;
    assign m_valid = (cnt_reg != '0);
    assign m_acc   = m_valid && m_ready;
    assign m_data  = q_reg[rd_ptr_reg];

    assign c        = s_data.char_byte;
    assign eos      = s_data.end_of_source || (c == CH_NUL);
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    assign is_nl    = (c == CH_NL);
    assign dig      = is_digit(c);
    assign alp      = is_alpha(c);
    assign opc      = is_op_char(c);
    assign quote    = (c == CH_QUOTE);
    assign slash    = (c == CH_SLASH);

    assign bp_inc    = (bp_reg == '1) ? bp_reg : bp_reg + PB'(1);
    assign line_inc  = (line_reg == FIELD_MAX) ? line_reg : line_reg + FIELD_BITS'(1);
    assign len_cur   = bp_reg - ts_reg;
    assign len_after = bp_inc - ts_reg;
    assign len_start = bp_inc - bp_reg;

    always_comb begin
        for (int j = 0; j < KW_MAX_LEN; j++) begin
            kw_word[j] = word_reg[j];
        end
    end

    assign kw_len = (len_cur <= PB'(KW_MAX_LEN)) ? len_cur[3:0] : 4'd0;

    // per mode: does this byte end the current token, and what it would be
    always_comb begin
        take_start = 1'b0;
        flush_able = 1'b0;
        flush_kind = KIND_NUMBER;
        case (mode_reg)
            MODE_IDLE: begin
                take_start = 1'b1;
            end
            MODE_COMMENT: begin
                take_start = is_nl;
            end
            MODE_STRING: begin
                take_start = 1'b0;
            end
            MODE_SLASH: begin
                take_start = !slash;
                flush_able = 1'b1;
                flush_kind = KIND_SLASH;
            end
            MODE_OP: begin
                take_start = (c != CH_EQUAL);
                flush_able = 1'b1;
                flush_kind = op_kind(pend_reg, 1'b0);
            end
            MODE_IDENT: begin
                take_start = !(alp || dig);
                flush_able = 1'b1;
                flush_kind = kw_lookup(kw_word, kw_len);
            end
            MODE_INT: begin
                take_start = !dig && (c != CH_DOT);
                flush_able = 1'b1;
            end
            MODE_FRAC: begin
                take_start = !dig;
                flush_able = 1'b1;
            end
            default: begin
                take_start = 1'b1;
            end
        endcase
    end

    // next state
    always_comb begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        ts_next   = ts_reg;
        bp_next   = bp_reg;
        line_next = line_reg;
        fin_next  = fin_reg;
        word_we   = 1'b0;
        word_idx  = '0;
        if (s_acc && !fin_reg) begin
            if (eos) begin
                mode_next = MODE_IDLE;
                fin_next  = 1'b1;
                if (mode_reg != MODE_STRING) begin
                    ts_next = bp_reg;
                end
            end else if (take_start) begin
                ts_next = bp_reg;
                bp_next = bp_inc;
                if (is_nl) begin
                    line_next = line_inc;
                end
                if (dig) begin
                    mode_next = MODE_INT;
                end else if (alp) begin
                    mode_next = MODE_IDENT;
                    word_we   = 1'b1;
                end else if (slash) begin
                    mode_next = MODE_SLASH;
                end else if (opc) begin
                    mode_next = MODE_OP;
                    pend_next = c;
                end else if (quote) begin
                    mode_next = MODE_STRING;
                end else begin
                    mode_next = MODE_IDLE;
                end
            end else begin
                bp_next = bp_inc;
                case (mode_reg)
                    MODE_STRING: begin
                        if (is_nl) begin
                            line_next = line_inc;
                        end
                        if (quote) begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_SLASH: begin
                        mode_next = MODE_COMMENT;
                    end
                    MODE_OP: begin
                        mode_next = MODE_IDLE;
                    end
                    MODE_IDENT: begin
                        if (len_cur < PB'(KEYWORD_CHARS)) begin
                            word_we  = 1'b1;
                            word_idx = len_cur[KW_IDX_BITS-1:0];
                        end
                    end
                    MODE_INT: begin
                        if (c == CH_DOT) begin
                            mode_next = MODE_FRAC;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // tokens caused by the current item
    always_comb begin
        flush_v   = 1'b0;
        sec_v     = 1'b0;
        flush_tok = mk_tok(flush_kind, ts_reg, len_cur, line_reg);
        sec_tok   = mk_tok(punct_kind(c), bp_reg, len_start, line_reg);
        if (!fin_reg) begin
            if (eos) begin
                if (mode_reg == MODE_STRING) begin
                    sec_v   = 1'b1;
                    sec_tok = mk_tok(KIND_ERR_STRING, ts_reg, len_cur, line_reg);
                end else begin
                    flush_v = flush_able;
                    sec_v   = 1'b1;
                    sec_tok = mk_tok(KIND_END, bp_reg, '0, line_reg);
                end
            end else if (take_start) begin
                flush_v = flush_able;
                sec_v   = !(is_blank || is_nl || dig || alp || slash || opc || quote);
            end else if (mode_reg == MODE_STRING) begin
                sec_v   = quote;
                sec_tok = mk_tok(KIND_STRING, ts_reg, len_after, line_reg);
            end else if (mode_reg == MODE_OP) begin
                sec_v   = 1'b1;
                sec_tok = mk_tok(op_kind(pend_reg, 1'b1), ts_reg, len_after, line_reg);
            end
        end
        r0    = flush_v ? flush_tok : sec_tok;
        r1    = sec_tok;
        n_res = {1'b0, flush_v} + {1'b0, sec_v};
        if (n_res == 2'd1) begin
            r0.last_of_run = 1'b1;
        end
        r1.last_of_run = 1'b1;
    end

    assign n_wr = s_acc ? n_res : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= '0;
            ts_reg     <= '0;
            bp_reg     <= '0;
            line_reg   <= FIELD_BITS'(1);
            fin_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            ts_reg     <= ts_next;
            bp_reg     <= bp_next;
            line_reg   <= line_next;
            fin_reg    <= fin_next;
            wr_ptr_reg <= wr_ptr_reg + QPTR'(n_wr);
            rd_ptr_reg <= rd_ptr_reg + QPTR'(m_acc);
            cnt_reg    <= cnt_reg + (QPTR+1)'(n_wr) - (QPTR+1)'(m_acc);
        end
    end

    always_ff @(posedge aclk) begin
        if (word_we) begin
            word_reg[word_idx] <= c;
        end
        if (n_wr != 2'd0) begin
            q_reg[wr_ptr_reg] <= r0;
        end
        if (n_wr == 2'd2) begin
            q_reg[wr_ptr_reg + QPTR'(1)] <= r1;
        end
    end

endmodule

/* rtl/stsc_checker.sv */
// port checks for the script token scanner, bound to the top level
`include "script_token_scanner_defines.svh"

module stsc_checker
    import stsc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    logic end_kind;
    logic end_len_ok;

    assign end_kind   = (m_data.token_kind == KIND_END) || (m_data.token_kind == KIND_ERR_STRING);
    assign end_len_ok = (m_data.token_kind != KIND_END) || (m_data.token_length == '0);

    // a waiting token holds until taken
    `STSC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // reset empties the result queue
    `STSC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid)

    // an empty result queue always takes the next item
    `STSC_ASSERT(a_ready_empty, !m_valid |-> s_ready)

    // end and unterminated string close the run of their item
    `STSC_ASSERT(a_end_last, m_valid && end_kind |-> m_data.last_of_run)

    // end token has no length and lines count from one
    `STSC_ASSERT(a_end_len, m_valid |-> m_data.line_number != '0 && end_len_ok)

endmodule

bind script_token_scanner stsc_checker u_stsc_checker (.*);

/* sim/tb_script_token_scanner.sv */
// self-checking testbench for the script token scanner: byte stream in, predicted tokens out
`timescale 1ns / 1ps

module tb_script_token_scanner;
    import stsc_pkg::*;

    localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS_DEF) - 1;
    localparam int LONG_HOLD = 200;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       typed;
        out_item_t  want;
    } src_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    script_token_scanner DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // lexer state mirrored by the testbench
    scan_mode_t      lex_mode = MODE_IDLE;
    logic [7:0]      op_char = '0;
    logic [7:0]      word_head [KEYWORD_CHARS_DEF] = '{default: '0};
    longint unsigned tok_begin = 0;
    longint unsigned next_pos = 0;
    longint unsigned cur_line = 1;
    bit              lex_done = 1'b0;

    out_item_t step_tokens[$];
    out_item_t tokens_due[$];
    src_row_t  bytes_in_flight[$];
    src_row_t  warmup_rows[$];
    src_row_t  source_rows[$];

    int err_count = 0;
    int src_gap_pct = 0;
    int sink_gap_pct = 0;
    bit hold_req = 1'b0;
    bit hold_served = 1'b0;
    int hold_left = 0;

    function automatic src_row_t src_item(logic [7:0] ch, logic eos);
        src_row_t r;
        r = '0;
        r.ch = ch;
        r.eos = eos;
        return r;
    endfunction

    function automatic src_row_t src_known(logic [7:0] ch, logic [KIND_BITS-1:0] kind,
                                           int unsigned off, int unsigned len);
        src_row_t r;
        r = src_item(ch, 1'b0);
        r.typed = 1'b1;
        r.want.token_kind = kind;
        r.want.token_offset = FIELD_BITS'(off);
        r.want.token_length = FIELD_BITS'(len);
        r.want.line_number = FIELD_BITS'(1);
        r.want.last_of_run = 1'b1;
        return r;
    endfunction

    function automatic logic [FIELD_BITS-1:0] clamp_field(longint unsigned v);
        return (v > FIELD_MAX) ? FIELD_MAX : FIELD_BITS'(v);
    endfunction

    function automatic bit dec_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit name_start(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER;
    endfunction

    function automatic void bump_pos();
        if (next_pos < POS_LIMIT) begin
            next_pos++;
        end
    endfunction

    function automatic void add_token(logic [KIND_BITS-1:0] kind);
        out_item_t t;
        longint unsigned len;
        len = (next_pos >= tok_begin) ? next_pos - tok_begin : 0;
        t.token_kind = kind;
        t.token_offset = clamp_field(tok_begin);
        t.token_length = clamp_field(len);
        t.line_number = clamp_field(cur_line);
        t.last_of_run = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic logic [KIND_BITS-1:0] op_token(logic [7:0] c, bit with_eq);
        case (c)
            CH_BANG:  return with_eq ? KIND_BANG_EQUAL : KIND_BANG;
            CH_EQUAL: return with_eq ? KIND_EQUAL_EQUAL : KIND_EQUAL;
            CH_LESS:  return with_eq ? KIND_LESS_EQUAL : KIND_LESS;
            default:  return with_eq ? KIND_GREATER_EQUAL : KIND_GREATER;
        endcase
    endfunction

    function automatic logic [KIND_BITS-1:0] punct_token(logic [7:0] c);
        case (c)
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            ",":     return KIND_COMMA;
            ".":     return KIND_DOT;
            "-":     return KIND_MINUS;
            "+":     return KIND_PLUS;
            ";":     return KIND_SEMICOLON;
            "*":     return KIND_STAR;
            default: return KIND_ERR_CHAR;
        endcase
    endfunction

    function automatic logic [KIND_BITS-1:0] word_kind();
        longint unsigned n;
        logic [63:0] w;
        logic [KIND_BITS-1:0] k;
        n = next_pos - tok_begin;
        w = '0;
        k = KIND_IDENT;
        if (n <= KEYWORD_CHARS_DEF) begin
            for (int i = 0; i < int'(n); i++) begin
                w = {w[55:0], word_head[i]};
            end
            case (w)
                "while":    k = KIND_WHILE;
                "if":       k = KIND_IF;
                "else":     k = KIND_ELSE;
                "True":     k = KIND_TRUE;
                "False":    k = KIND_FALSE;
                "Nil":      k = KIND_NIL;
                "or":       k = KIND_OR;
                "and":      k = KIND_AND;
                "return":   k = KIND_RETURN;
                "var":      k = KIND_VAR;
                "super":    k = KIND_SUPER;
                "print":    k = KIND_PRINT;
                "class":    k = KIND_CLASS;
                "function": k = KIND_FUNCTION;
                "for":      k = KIND_FUNCTION;
                default:    k = KIND_IDENT;
            endcase
        end
        return k;
    endfunction

    function automatic void begin_token(logic [7:0] c);
        tok_begin = next_pos;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
            bump_pos();
        end else if (c == CH_NL) begin
            if (cur_line < FIELD_MAX) begin
                cur_line++;
            end
            bump_pos();
        end else if (dec_digit(c)) begin
            lex_mode = MODE_INT;
            bump_pos();
        end else if (name_start(c)) begin
            word_head[0] = c;
            lex_mode = MODE_IDENT;
            bump_pos();
        end else if (c == CH_SLASH) begin
            lex_mode = MODE_SLASH;
            bump_pos();
        end else if (c == CH_BANG || c == CH_EQUAL || c == CH_LESS || c == CH_GREATER) begin
            op_char = c;
            lex_mode = MODE_OP;
            bump_pos();
        end else if (c == CH_QUOTE) begin
            lex_mode = MODE_STRING;
            bump_pos();
        end else begin
            bump_pos();
            add_token(punct_token(c));
        end
    endfunction

    function automatic void flush_token();
        case (lex_mode)
            MODE_SLASH:           add_token(KIND_SLASH);
            MODE_IDENT:           add_token(word_kind());
            MODE_INT, MODE_FRAC:  add_token(KIND_NUMBER);
            MODE_OP:              add_token(op_token(op_char, 1'b0));
            default: ;
        endcase
        lex_mode = MODE_IDLE;
    endfunction

    function automatic void lex_step(logic [7:0] c, logic eos);
        longint unsigned idx;
        step_tokens.delete();
        if (lex_done) begin
            return;
        end
        if (eos || c == CH_NUL) begin
            if (lex_mode == MODE_STRING) begin
                add_token(KIND_ERR_STRING);
            end else begin
                flush_token();
                tok_begin = next_pos;
                add_token(KIND_END);
            end
            lex_mode = MODE_IDLE;
            lex_done = 1'b1;
        end else begin
            case (lex_mode)
                MODE_COMMENT: begin
                    if (c == CH_NL) begin
                        lex_mode = MODE_IDLE;
                        begin_token(c);
                    end else begin
                        bump_pos();
                    end
                end
                MODE_STRING: begin
                    bump_pos();
                    if (c == CH_NL && cur_line < FIELD_MAX) begin
                        cur_line++;
                    end
                    if (c == CH_QUOTE) begin
                        add_token(KIND_STRING);
                        lex_mode = MODE_IDLE;
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        lex_mode = MODE_COMMENT;
                        bump_pos();
                    end else begin
                        flush_token();
                        begin_token(c);
                    end
                end
                MODE_OP: begin
                    if (c == CH_EQUAL) begin
                        bump_pos();
                        add_token(op_token(op_char, 1'b1));
                        lex_mode = MODE_IDLE;
                    end else begin
                        flush_token();
                        begin_token(c);
                    end
                end
                MODE_IDENT: begin
                    if (name_start(c) || dec_digit(c)) begin
                        idx = next_pos - tok_begin;
                        if (idx < KEYWORD_CHARS_DEF) begin
                            word_head[idx] = c;
                        end
                        bump_pos();
                    end else begin
                        flush_token();
                        begin_token(c);
                    end
                end
                MODE_INT: begin
                    if (dec_digit(c)) begin
                        bump_pos();
                    end else if (c == CH_DOT) begin
                        lex_mode = MODE_FRAC;
                        bump_pos();
                    end else begin
                        flush_token();
                        begin_token(c);
                    end
                end
                MODE_FRAC: begin
                    if (dec_digit(c)) begin
                        bump_pos();
                    end else begin
                        flush_token();
                        begin_token(c);
                    end
                end
                default: begin
                    lex_mode = MODE_IDLE;
                    begin_token(c);
                end
            endcase
        end
        if (step_tokens.size() > 0) begin
            step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
        end
    endfunction

    // prediction on accepted bytes, comparison on accepted tokens
    always @(posedge aclk) begin
        src_row_t  row;
        out_item_t due;
        if (aresetn && s_valid && s_ready) begin
            row = bytes_in_flight.pop_front();
            lex_step(row.ch, row.eos);
            if (row.typed) begin
                tokens_due.push_back(row.want);
            end else begin
                foreach (step_tokens[i]) begin
                    tokens_due.push_back(step_tokens[i]);
                end
            end
        end
        if (aresetn && m_valid && m_ready) begin
            if (tokens_due.size() == 0) begin
                $error("unexpected item: token_kind %0d token_offset %0d",
                       m_data.token_kind, m_data.token_offset);
                err_count++;
            end else begin
                due = tokens_due.pop_front();
                if (m_data.token_kind !== due.token_kind) begin
                    $error("token_kind: expected %0d, got %0d", due.token_kind, m_data.token_kind);
                    err_count++;
                end
                if (m_data.token_offset !== due.token_offset) begin
                    $error("token_offset: expected %0d, got %0d",
                           due.token_offset, m_data.token_offset);
                    err_count++;
                end
                if (m_data.token_length !== due.token_length) begin
                    $error("token_length: expected %0d, got %0d",
                           due.token_length, m_data.token_length);
                    err_count++;
                end
                if (m_data.line_number !== due.line_number) begin
                    $error("line_number: expected %0d, got %0d",
                           due.line_number, m_data.line_number);
                    err_count++;
                end
                if (m_data.last_of_run !== due.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d",
                           due.last_of_run, m_data.last_of_run);
                    err_count++;
                end
            end
        end
    end

    // token sink with random back-pressure and one long hold
    always @(negedge aclk) begin
        if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    task automatic offer(src_row_t r);
        while ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        bytes_in_flight.push_back(r);
        s_valid <= 1'b1;
        s_data <= '{char_byte: r.ch, end_of_source: r.eos};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        string      kw_words [15];
        string      punct_set;
        string      op_set;
        string      blank_set;
        string      word_set;
        string      w;
        logic [7:0] text[$];
        logic [7:0] c;
        int         pick;
        int         n_rows;
        int         waited;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;

        kw_words = '{"while", "if", "else", "True", "False", "Nil", "or", "and", "return",
                     "var", "super", "print", "class", "function", "for"};
        punct_set = "(){},.-+;*";
        op_set = "!=<>";
        blank_set = " \t\r\n";
        word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

        warmup_rows = '{
            src_known("(", KIND_LPAREN, 0, 1),
            src_known("@", KIND_ERR_CHAR, 1, 1),
            src_known(8'hFF, KIND_ERR_CHAR, 2, 1),
            src_known(8'h01, KIND_ERR_CHAR, 3, 1),
            src_item(CH_BANG, 1'b0),
            src_known(CH_EQUAL, KIND_BANG_EQUAL, 4, 2),
            src_item(CH_LESS, 1'b0),
            src_item("7", 1'b0),
            src_item(CH_DOT, 1'b0),
            src_item(CH_SPACE, 1'b0),
            src_item(CH_QUOTE, 1'b0),
            src_item("a", 1'b0),
            src_item(CH_NL, 1'b0),
            src_item(CH_QUOTE, 1'b0),
            src_item(CH_SLASH, 1'b0),
            src_item(CH_SLASH, 1'b0),
            src_item("x", 1'b0),
            src_item(CH_NL, 1'b0),
            src_item(CH_SLASH, 1'b0),
            src_item("i", 1'b0),
            src_item("f", 1'b0),
            src_item(CH_EQUAL, 1'b0),
            src_item(CH_EQUAL, 1'b0),
            src_item(CH_GREATER, 1'b0),
            src_item(CH_TAB, 1'b0),
            src_item(CH_CR, 1'b0)
        };

        // mostly well-formed source text, with some stray bytes mixed in
        while (text.size() < 815) begin
            pick = $urandom_range(99);
            if (pick < 14) begin
                w = kw_words[$urandom_range(14)];
                foreach (w[j]) text.push_back(w[j]);
            end else if (pick < 20) begin
                w = kw_words[$urandom_range(14)];
                if ($urandom_range(1)) begin
                    for (int j = 0; j < w.len() - 1; j++) text.push_back(w[j]);
                end else begin
                    foreach (w[j]) text.push_back(w[j]);
                    text.push_back(word_set[$urandom_range(62)]);
                end
            end else if (pick < 28) begin
                text.push_back(word_set[$urandom_range(52)]);
                repeat ($urandom_range(11)) text.push_back(word_set[$urandom_range(62)]);
            end else if (pick < 37) begin
                repeat ($urandom_range(1, 4)) text.push_back("0" + 8'($urandom_range(9)));
                if ($urandom_range(1)) begin
                    text.push_back(CH_DOT);
                    repeat ($urandom_range(3)) text.push_back("0" + 8'($urandom_range(9)));
                end
            end else if (pick < 45) begin
                text.push_back(CH_QUOTE);
                repeat ($urandom_range(6)) begin
                    c = 8'($urandom_range(1, 255));
                    text.push_back(c == CH_QUOTE ? CH_NL : c);
                end
                text.push_back(CH_QUOTE);
            end else if (pick < 60) begin
                text.push_back(punct_set[$urandom_range(9)]);
            end else if (pick < 70) begin
                text.push_back(op_set[$urandom_range(3)]);
                if ($urandom_range(1)) text.push_back(CH_EQUAL);
            end else if (pick < 75) begin
                text.push_back(CH_SLASH);
                if ($urandom_range(1)) begin
                    text.push_back(CH_SLASH);
                    repeat ($urandom_range(5)) begin
                        c = 8'($urandom_range(1, 255));
                        text.push_back(c == CH_NL ? CH_SPACE : c);
                    end
                    text.push_back(CH_NL);
                end
            end else if (pick < 88) begin
                text.push_back(blank_set[$urandom_range(3)]);
            end else begin
                text.push_back(8'($urandom_range(1, 255)));
            end
            if ($urandom_range(1)) text.push_back(CH_SPACE);
        end
        if ($urandom_range(2) == 0) begin
            text.push_back(CH_QUOTE);
            text.push_back("z");
        end
        foreach (text[j]) source_rows.push_back(src_item(text[j], 1'b0));
        n_rows = source_rows.size();

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_gap_pct = 38;
        sink_gap_pct <= 52;
        foreach (warmup_rows[i]) offer(warmup_rows[i]);

        for (int i = 0; i < n_rows; i++) begin
            if (i == n_rows / 3) begin
                src_gap_pct = 52;
                sink_gap_pct <= 38;
            end
            if (i == 2 * n_rows / 3) begin
                src_gap_pct = 0;
                sink_gap_pct <= 0;
                hold_req <= 1'b1;
            end
            offer(source_rows[i]);
        end

        if ($urandom_range(1)) begin
            offer(src_item(8'($urandom_range(255)), 1'b1));
        end else begin
            offer(src_item(CH_NUL, 1'b0));
        end
        // everything after the end of the source must be dropped
        offer(src_item(CH_NUL, 1'b0));
        repeat (6) offer(src_item(8'($urandom_range(255)), 1'($urandom_range(1))));
        s_valid <= 1'b0;

        waited = 0;
        while (tokens_due.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (tokens_due.size() != 0) begin
            $error("%0d expected tokens never arrived", tokens_due.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
